>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked in reset
`define SKVT_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, masked in reset
`define SKVT_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> hw/rtl/skvt_pkg.sv
// Package for the sorted key/value table: defaults, request and status codes,
// and the sequencer state type. No dependencies.
package skvt_pkg;

  localparam int SKVT_ENTRIES     = 256;
  localparam int SKVT_KEY_WIDTH   = 32;
  localparam int SKVT_VALUE_WIDTH = 32;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int FIELD_W  = 32;

  localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 9'd256;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP       = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_DECIDE,
    ST_SHUP,
    ST_SHDN
  } state_t;

endpackage

>>> hw/rtl/sorted_key_value_table_top.sv
// Sorted key/value table top level: sequencer, binary search and shift engine.
// Depends on skvt_pkg and skvt_ram.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------------
//  request  | in_kind, in_key_in, in_value_in         | start high while busy low
//  result   | out_status, out_value_out, out_count_out| out_valid, one-cycle strobe
//  config   | cfg_data (max_entries)                  | cfg_we, taken at the edge
//
//  Search: each halving step reads the midpoint (ST_SRCH) and compares it (ST_CMP),
//  then ST_DECIDE; insert then shifts entries up in ST_SHUP, remove down in ST_SHDN;
//  longest busy run: remove of the smallest key at 256 entries.
//  One memory move per cycle, set by the single read and write port of the entry RAM.
//  Reset clears count, sets the limit to 256; entries above the count are never used.
//  The result strobe cannot be stalled; busy stays high until the result shows.
module sorted_key_value_table_top
  import skvt_pkg::*;
#(
  parameter int ENTRIES     = SKVT_ENTRIES,
  parameter int KEY_WIDTH   = SKVT_KEY_WIDTH,
  parameter int VALUE_WIDTH = SKVT_VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [FIELD_W-1:0]  in_key_in,
  input  logic [FIELD_W-1:0]  in_value_in,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [FIELD_W-1:0]  out_value_out,
  output logic [COUNT_W-1:0]  out_count_out,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_data
);

  localparam int AW = $clog2(ENTRIES);        // entry address
  localparam int CW = $clog2(ENTRIES + 1);    // count, holds ENTRIES itself
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int DW = KEY_WIDTH + VALUE_WIDTH;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]     max_entries_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;       // value to insert
  logic [VALUE_WIDTH-1:0] hitval_r, hitval_nxt; // value at candidate position
  logic                   found_r, found_nxt;
  logic [CW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   pend_r, pend_nxt;     // a moved entry waits for its write
  logic [AW-1:0]          pend_addr_r, pend_addr_nxt;

  logic                   out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_nxt;
  logic [FIELD_W-1:0]     out_value_nxt;
  logic [COUNT_W-1:0]     out_count_nxt;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [DW-1:0] ram_wr_data, ram_rd_data;

  // width fitting of the request and result fields
  logic [63:0]          key64, val64, hit64;
  logic [KEY_WIDTH-1:0] in_key_k;
  logic [VALUE_WIDTH-1:0] in_val_v;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid_c;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [LW-1:0]        cnt_ext, lim_ext, cnt_out_ext;
  logic                 full;

  assign key64    = 64'(in_key_in);
  assign val64    = 64'(in_value_in);
  assign in_key_k = key64[KEY_WIDTH-1:0];
  assign in_val_v = val64[VALUE_WIDTH-1:0];
  assign hit64    = 64'(hitval_r);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[CW:1];
  assign rd_key  = ram_rd_data[DW-1:VALUE_WIDTH];

  // full when count reaches the configured limit or the physical depth
  assign cnt_ext = LW'(count_r);
  assign lim_ext = LW'(max_entries_r);
  assign full    = (cnt_ext >= lim_ext) || (cnt_ext >= LW'(ENTRIES));

  assign busy = (state_r != ST_IDLE);

  skvt_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hitval_nxt     = hitval_r;
    found_nxt      = found_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_value_nxt  = '0;
    ram_we         = 1'b0;
    ram_wr_addr    = pend_addr_r;
    ram_wr_data    = ram_rd_data;
    ram_rd_addr    = mid_c[AW-1:0];
    cnt_out_ext    = LW'(count_r);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key_k;
          val_nxt   = in_val_v;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          found_nxt = 1'b0;
          state_nxt = ST_SRCH;
        end
      end

      // issue a read of the midpoint, or stop when the range is empty
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end

      // the one shared comparator; the last hi move remembers equality
      ST_CMP: begin
        if (key_r > rd_key) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt     = mid_r;
          found_nxt  = (key_r == rd_key);
          hitval_nxt = ram_rd_data[VALUE_WIDTH-1:0];
        end
        state_nxt = ST_SRCH;
      end

      ST_DECIDE: begin
        priority if (kind_r == KIND_INSERT) begin
          if (found_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_DUP;
            state_nxt      = ST_IDLE;
          end else if (full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
            state_nxt      = ST_IDLE;
          end else begin
            idx_nxt   = count_r;
            pend_nxt  = 1'b0;
            state_nxt = ST_SHUP;
          end
        end else if (kind_r == KIND_LOOKUP) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = found_r ? STAT_OK : STAT_NOT_FOUND;
          out_value_nxt  = found_r ? hit64[FIELD_W-1:0] : '0;
          state_nxt      = ST_IDLE;
        end else if (kind_r == KIND_REMOVE) begin
          if (found_r) begin
            idx_nxt   = lo_r + CW'(1);
            pend_nxt  = 1'b0;
            state_nxt = ST_SHDN;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NOT_FOUND;
            state_nxt      = ST_IDLE;
          end
        end else begin
          // unused kind: no change
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // shift up: read idx-1 while the previous read lands at its new slot
      ST_SHUP: begin
        ram_rd_addr = AW'(idx_r - CW'(1));
        if (pend_r) begin
          ram_we = 1'b1;
        end
        pend_nxt = 1'b0;
        if (idx_r > lo_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_r - CW'(1);
        end else if (!pend_r) begin
          ram_we         = 1'b1;
          ram_wr_addr    = lo_r[AW-1:0];
          ram_wr_data    = {key_r, val_r};
          count_nxt      = count_r + CW'(1);
          cnt_out_ext    = LW'(count_nxt);
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      // shift down: read idx, write it one slot lower next cycle
      ST_SHDN: begin
        ram_rd_addr = idx_r[AW-1:0];
        if (pend_r) begin
          ram_we = 1'b1;
        end
        pend_nxt = 1'b0;
        if (idx_r < count_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(idx_r - CW'(1));
          idx_nxt       = idx_r + CW'(1);
        end else if (!pend_r) begin
          count_nxt     = count_r - CW'(1);
          cnt_out_ext   = LW'(count_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_count_nxt = cnt_out_ext[COUNT_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid     <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_valid <= out_valid_nxt;
      pend_r    <= pend_nxt;
      if (cfg_we) begin
        max_entries_r <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    key_r         <= key_nxt;
    val_r         <= val_nxt;
    hitval_r      <= hitval_nxt;
    found_r       <= found_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    idx_r         <= idx_nxt;
    pend_addr_r   <= pend_addr_nxt;
    out_status    <= out_status_nxt;
    out_value_out <= out_value_nxt;
    out_count_out <= out_count_nxt;
  end

endmodule

>>> hw/rtl/skvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/skvt_checker.sv
// Port-level checks for the sorted key/value table, bound to the top level.
// Depends on skvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skvt_checker
  import skvt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [FIELD_W-1:0]  out_value_out
);

  // an accepted request holds the block busy
  `SKVT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
  // busy only starts from an accepted request
  `SKVT_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start), "busy rose without a request")
  // a result ends the work, and no two results come back to back
  `SKVT_ASSERT_IMPL(a_done_idle, out_valid, !busy, "result while still busy")
  `SKVT_ASSERT_NEXT(a_one_strobe, out_valid, !out_valid, "result strobe longer than a cycle")
  // only a successful result may carry a value
  `SKVT_ASSERT_IMPL(a_value_zero, out_valid && (out_status != STAT_OK), out_value_out == '0,
    "value on a failed result")

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_value_out (out_value_out)
);

>>> test/sorted_key_value_table_top_tb.sv
`timescale 1ns / 100ps
// Testbench for sorted_key_value_table_top: insert, lookup and remove requests
// checked against a sorted-queue predictor of the table. Needs skvt_pkg and the RTL.

import skvt_pkg::*;

// Expected result of one request.
typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  value;
  logic [COUNT_W-1:0]  count;
} table_result_t;

class table_scoreboard;
  logic [FIELD_W-1:0] keys[$];
  logic [FIELD_W-1:0] vals[$];
  int unsigned        limit;
  table_result_t      results_due[$];
  int unsigned        errors;

  function new();
    limit  = MAX_ENTRIES_RST;
    errors = 0;
  endfunction

  // limit above the table size acts as the table size
  function void set_limit(logic [COUNT_W-1:0] lim);
    limit = (lim > SKVT_ENTRIES) ? SKVT_ENTRIES : lim;
  endfunction

  function int first_not_less(logic [FIELD_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = keys.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (k > keys[mid]) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function logic [FIELD_W-1:0] stored_key();
    return keys[$urandom_range(0, keys.size() - 1)];
  endfunction

  function int pending();
    return results_due.size();
  endfunction

  // apply an accepted request to the predicted table, queue its result
  function void note_request(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] k,
                             logic [FIELD_W-1:0] v);
    table_result_t r;
    int pos;
    bit hit;
    pos      = first_not_less(k);
    hit      = (pos < keys.size()) && (keys[pos] == k);
    r.status = STAT_OK;
    r.value  = '0;
    case (kind)
      KIND_INSERT: begin
        if (hit) r.status = STAT_DUP;
        else if (keys.size() >= limit) r.status = STAT_FULL;
        else begin
          keys.insert(pos, k);
          vals.insert(pos, v);
        end
      end
      KIND_LOOKUP: begin
        if (hit) r.value = vals[pos];
        else r.status = STAT_NOT_FOUND;
      end
      KIND_REMOVE: begin
        if (hit) begin
          keys.delete(pos);
          vals.delete(pos);
        end else r.status = STAT_NOT_FOUND;
      end
      default: ;
    endcase
    r.count = COUNT_W'(keys.size());
    results_due.push_back(r);
  endfunction

  function void check_result(logic [STATUS_W-1:0] status, logic [FIELD_W-1:0] value,
                             logic [COUNT_W-1:0] count);
    table_result_t want;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected result: status %0d value %h count %0d",
               $time, status, value, count);
      errors++;
      return;
    end
    want = results_due.pop_front();
    if (status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      errors++;
    end
    if (value !== want.value) begin
      $display("%0t: value_out expected %h actual %h", $time, want.value, value);
      errors++;
    end
    if (count !== want.count) begin
      $display("%0t: count_out expected %0d actual %0d", $time, want.count, count);
      errors++;
    end
  endfunction
endclass

module sorted_key_value_table_top_tb;
  import skvt_pkg::*;

  // kind three has no meaning in the block; it must leave the table alone
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // bound above the longest request plus the longest sender gap
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [FIELD_W-1:0]  in_key_in;
  logic [FIELD_W-1:0]  in_value_in;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_value_out;
  logic [COUNT_W-1:0]  out_count_out;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_data;

  table_scoreboard sb = new();

  int burst_left = 0;

  sorted_key_value_table_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_key_in    (in_key_in),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_value_out(out_value_out),
    .out_count_out(out_count_out),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are a one-cycle strobe with no back-pressure, so every
  // rising edge with out_valid high carries one result to check.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_value_out, out_count_out);
  end

  // Watchdog: any edge that moves a request or a result resets the count.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Present one request at the falling edge and hold it until an edge
  // finds busy low. Start stays high afterwards so a burst runs back to back.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] k,
                              logic [FIELD_W-1:0] v);
    @(negedge clk);
    start       <= 1'b1;
    in_kind     <= kind;
    in_key_in   <= k;
    in_value_in <= v;
    do @(posedge clk); while (busy);
    sb.note_request(kind, k, v);
  endtask

  // Sender pacing: bursts of random length, random gaps between them.
  // Gaps start right after an acceptance, so they land on every phase of
  // the search and shift work; the odd long gap lets the block go idle.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 12);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
    burst_left = 0;
  endtask

  // Register write, only ever issued from an idle block.
  task automatic write_limit(logic [COUNT_W-1:0] lim);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(lim);
  endtask

  // Random request. Inserts mostly use fresh keys so the table fills;
  // lookups and removes mostly use keys already held so they hit.
  // In the filling phase keys not taken from the held ones are full random keys, so the table reaches its depth.
  task automatic random_request(int ins_pct);
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] k;
    int r;
    int sel;
    int hold_pct;
    r = $urandom_range(0, 99);
    if (r < ins_pct) kind = KIND_INSERT;
    else if (r < ins_pct + 3) kind = KIND_UNUSED;
    else if ($urandom_range(0, 1) == 0) kind = KIND_LOOKUP;
    else kind = KIND_REMOVE;
    hold_pct = (kind == KIND_INSERT) ? 2 : 7;
    sel = $urandom_range(0, 9);
    if (sel < hold_pct && sb.keys.size() > 0) k = sb.stored_key();
    else if (sel < 9 && ins_pct < 90) k = 32'h8000_0000 + $urandom_range(0, 63);  // small pool
    else k = $urandom;
    pace();
    send_request(kind, k, $urandom);
  endtask

  initial begin : stimulus
    int          lims[9]     = '{511, 256, 5, 1, 0, 300, 37, 128, 256};
    int          ins_pcts[9] = '{90, 50, 15, 30, 40, 80, 40, 50, 60};
    int          counts[9]   = '{400, 200, 220, 150, 120, 230, 200, 200, 180};

    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_INSERT;
    in_key_in   = '0;
    in_value_in = '0;
    cfg_we      = 1'b0;
    cfg_data    = MAX_ENTRIES_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, key extremes, duplicates, every kind.
    send_request(KIND_LOOKUP, 32'd5, 32'hFFFF_FFFF);
    send_request(KIND_REMOVE, 32'd5, 32'd0);
    send_request(KIND_UNUSED, 32'd0, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
    send_request(KIND_INSERT, 32'h8000_0000, 32'h0000_0001);
    send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    send_request(KIND_LOOKUP, 32'h0000_0000, 32'd0);
    send_request(KIND_LOOKUP, 32'h7FFF_FFFF, 32'd0);
    send_request(KIND_REMOVE, 32'h8000_0000, 32'd0);
    send_request(KIND_REMOVE, 32'h8000_0000, 32'd0);
    send_request(KIND_INSERT, 32'h0000_0001, 32'h5555_5555);

    // Limit dropped below the count: entries stay, inserts refused as full,
    // but a duplicate still reports duplicate.
    write_limit(9'd1);
    send_request(KIND_INSERT, 32'h0000_1234, 32'h1);
    send_request(KIND_INSERT, 32'h0000_0000, 32'h2);
    send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'd0);
    send_request(KIND_REMOVE, 32'h0000_0001, 32'd0);
    send_request(KIND_INSERT, 32'h0000_0007, 32'h3);
    send_request(KIND_REMOVE, 32'h0000_0000, 32'd0);
    send_request(KIND_INSERT, 32'h0000_0007, 32'h4);

    // Zero limit refuses every insert.
    write_limit(9'd0);
    send_request(KIND_REMOVE, 32'h0000_0007, 32'd0);
    send_request(KIND_INSERT, 32'h0000_0009, 32'h5);

    // Limit past the table size behaves as the table size.
    write_limit(9'd511);
    send_request(KIND_INSERT, 32'h0000_0009, 32'h6);
    send_request(KIND_UNUSED, 32'h0000_0009, 32'hFFFF_FFFF);
    send_request(KIND_LOOKUP, 32'h0000_0009, 32'd0);

    // Random phases, each under its own limit; the first fills the table.
    for (int p = 0; p < 9; p++) begin
      write_limit(COUNT_W'(lims[p]));
      repeat (counts[p]) random_request(ins_pcts[p]);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_ram.sv
hw/rtl/sorted_key_value_table_top.sv
hw/rtl/skvt_checker.sv
test/sorted_key_value_table_top_tb.sv
